// ----- hw/rtl/gpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types, constants and tables for the gnomonic projection core.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ANG_W = 37;
    localparam int CW    = 34;
    localparam int DIV_STEPS = 32;
    localparam int IDX_W = 1;

    localparam logic IDX_CENTER_COLAT = 1'b0;
    localparam logic IDX_CENTER_LON   = 1'b1;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 37'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 37'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 37'sd6746518852;
    localparam logic signed [CW-1:0]    Q30_GAIN    = 34'sd652032874;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } cordic_t;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] nlo;
        logic [31:0] q;
        logic [31:0] c;
    } div_t;

    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic ovf_u;
        logic ovf_v;
        logic hz;
    } side_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] k);
        logic signed [CW-1:0] a;
        case (k)
            5'd0:  a = 34'sd843314857;
            5'd1:  a = 34'sd497837829;
            5'd2:  a = 34'sd263043837;
            5'd3:  a = 34'sd133525159;
            5'd4:  a = 34'sd67021687;
            5'd5:  a = 34'sd33543516;
            5'd6:  a = 34'sd16775851;
            5'd7:  a = 34'sd8388437;
            5'd8:  a = 34'sd4194283;
            5'd9:  a = 34'sd2097149;
            5'd10: a = 34'sd1048576;
            5'd11: a = 34'sd524288;
            5'd12: a = 34'sd262144;
            5'd13: a = 34'sd131072;
            5'd14: a = 34'sd65536;
            5'd15: a = 34'sd32768;
            5'd16: a = 34'sd16384;
            5'd17: a = 34'sd8192;
            5'd18: a = 34'sd4096;
            5'd19: a = 34'sd2048;
            5'd20: a = 34'sd1024;
            5'd21: a = 34'sd512;
            5'd22: a = 34'sd256;
            5'd23: a = 34'sd128;
            5'd24: a = 34'sd64;
            5'd25: a = 34'sd32;
            5'd26: a = 34'sd16;
            5'd27: a = 34'sd8;
            5'd28: a = 34'sd4;
            5'd29: a = 34'sd2;
            5'd30: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- hw/rtl/gpc_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// gpc_cordic_cell
// One rotation-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
module gpc_cordic_cell
    import gpc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [4:0]       k,
    input  cordic_t          d_in,
    output cordic_t          d_out
);

    cordic_t d_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb begin
        xs = d_in.x >>> k;
        ys = d_in.y >>> k;
        d_next.neg = d_in.neg;
        if (!d_in.z[CW-1]) begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - atan_q30(k);
        end else begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + atan_q30(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_out <= d_next;
        end
    end

endmodule

// ----- hw/rtl/gpc_div_cell.sv -----
// ----------------------------------------------------------------------------
// gpc_div_cell
// One restoring division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module gpc_div_cell
    import gpc_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    div_t        d_next;
    logic [32:0] rr;
    logic [32:0] diff;

    always_comb begin
        rr   = {d_in.r, d_in.nlo[31]};
        diff = rr - {1'b0, d_in.c};
        d_next.c   = d_in.c;
        d_next.nlo = {d_in.nlo[30:0], 1'b0};
        if (!diff[32]) begin
            d_next.r = diff[31:0];
            d_next.q = {d_in.q[30:0], 1'b1};
        end else begin
            d_next.r = rr[31:0];
            d_next.q = {d_in.q[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_out <= d_next;
        end
    end

endmodule

// ----- hw/rtl/gnomonic_projection_core.sv -----
// ----------------------------------------------------------------------------
// gnomonic_projection_core
// Forward gnomonic projection: sphere point to tangent-plane u, v.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls; the chain of CORDIC and divider cells sets it.
// Stall: the whole chain holds while a result waits on m_tready.
// Reset: aresetn clears all valid bits and the center registers; no clearing pass.
// ----------------------------------------------------------------------------
module gnomonic_projection_core
    import gpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // point_colatitude[29:0], point_longitude[61:30]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // u_coord[31:0], v_coord[63:32]
    output logic              m_tuser,   // beyond_horizon
    output logic              m_tlast
);

    localparam int P_CIN  = 4;
    localparam int P_NEG  = P_CIN + CORDIC_ITERATIONS + 1;
    localparam int P_DIN  = P_NEG + 4;
    localparam int P_OUT  = P_DIN + DIV_STEPS + 1;
    localparam int NSTG   = P_OUT + 1;

    logic [29:0] ccolat_reg;
    logic [31:0] clon_reg;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] lst_reg;
    logic adv;

    assign adv = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ccolat_reg <= '0;
            clon_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                IDX_CENTER_COLAT: ccolat_reg <= cfg_data[29:0];
                IDX_CENTER_LON:   clon_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lst_reg <= {lst_reg[NSTG-2:0], s_tlast};
        end
    end

    // angle reduction: input stage then three 2*pi steps
    logic signed [ANG_W-1:0] ang_reg [4][3];
    logic signed [32:0]      dlon;

    assign dlon = $signed({s_tdata[61], s_tdata[61:30]}) - $signed({clon_reg[31], clon_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg[0][0] <= $signed({5'b0, ccolat_reg, 2'b00});
            ang_reg[0][1] <= $signed({5'b0, s_tdata[29:0], 2'b00});
            ang_reg[0][2] <= $signed({{2{dlon[32]}}, dlon, 2'b00});
            for (int s = 1; s < 4; s++) begin
                for (int l = 0; l < 3; l++) begin
                    if (ang_reg[s-1][l] > Q30_PI) begin
                        ang_reg[s][l] <= ang_reg[s-1][l] - Q30_TWO_PI;
                    end else if (ang_reg[s-1][l] < -Q30_PI) begin
                        ang_reg[s][l] <= ang_reg[s-1][l] + Q30_TWO_PI;
                    end else begin
                        ang_reg[s][l] <= ang_reg[s-1][l];
                    end
                end
            end
        end
    end

    cordic_t fold_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                fold_reg[l].x <= Q30_GAIN;
                fold_reg[l].y <= '0;
                if (ang_reg[3][l] > Q30_HALF_PI) begin
                    fold_reg[l].z   <= CW'(ang_reg[3][l] - Q30_PI);
                    fold_reg[l].neg <= 1'b1;
                end else if (ang_reg[3][l] < -Q30_HALF_PI) begin
                    fold_reg[l].z   <= CW'(ang_reg[3][l] + Q30_PI);
                    fold_reg[l].neg <= 1'b1;
                end else begin
                    fold_reg[l].z   <= CW'(ang_reg[3][l]);
                    fold_reg[l].neg <= 1'b0;
                end
            end
        end
    end

    cordic_t cw [3][CORDIC_ITERATIONS+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cw[l][0] = fold_reg[l];
        for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_step
            gpc_cordic_cell u_cell (
                .aclk  (aclk),
                .en    (adv),
                .k     (5'(i)),
                .d_in  (cw[l][i]),
                .d_out (cw[l][i+1])
            );
        end
    end

    // lanes: 0 = center, 1 = point colatitude, 2 = longitude difference
    logic signed [CW-1:0] sin_reg [3];
    logic signed [CW-1:0] cos_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                sin_reg[l] <= cw[l][CORDIC_ITERATIONS].neg ?
                              -cw[l][CORDIC_ITERATIONS].y : cw[l][CORDIC_ITERATIONS].y;
                cos_reg[l] <= cw[l][CORDIC_ITERATIONS].neg ?
                              -cw[l][CORDIC_ITERATIONS].x : cw[l][CORDIC_ITERATIONS].x;
            end
        end
    end

    logic signed [2*CW-1:0] p_ctfct_reg, p_stfct_reg, p_stsd_reg;
    logic signed [2*CW-1:0] p_stcd;
    logic signed [CW-1:0]   stcd_reg, stf1_reg, ctf1_reg;
    logic signed [2*CW-1:0] p_ctfct2_reg, p_stfct2_reg, p_stcdstf_reg, p_ctfstcd_reg;
    logic signed [CW-1:0]   nu2_reg;
    logic signed [2*CW:0]   sum_c, sum_v;
    logic signed [CW-1:0]   cosc_reg, nv_reg, nu3_reg;

    assign p_stcd = sin_reg[1] * cos_reg[2];
    assign sum_c  = p_ctfct2_reg + p_stcdstf_reg;
    assign sum_v  = p_stfct2_reg - p_ctfstcd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_ctfct_reg   <= cos_reg[0] * cos_reg[1];
            p_stfct_reg   <= sin_reg[0] * cos_reg[1];
            p_stsd_reg    <= sin_reg[1] * sin_reg[2];
            stcd_reg      <= CW'(p_stcd >>> 30);
            stf1_reg      <= sin_reg[0];
            ctf1_reg      <= cos_reg[0];
            p_stcdstf_reg <= stcd_reg * stf1_reg;
            p_ctfstcd_reg <= ctf1_reg * stcd_reg;
            p_ctfct2_reg  <= p_ctfct_reg;
            p_stfct2_reg  <= p_stfct_reg;
            nu2_reg       <= CW'(p_stsd_reg >>> 30);
            cosc_reg      <= CW'(sum_c >>> 30);
            nv_reg        <= CW'(sum_v >>> 30);
            nu3_reg       <= nu2_reg;
        end
    end

    logic                 hz;
    logic [31:0]          dv_c;
    logic [CW-1:0]        abs_u, abs_v;
    div_t                 dw_u [DIV_STEPS+1];
    div_t                 dw_v [DIV_STEPS+1];
    div_t                 din_u_reg, din_v_reg;
    side_t                side_reg [DIV_STEPS+1];

    assign hz    = cosc_reg[CW-1] || (cosc_reg == '0);
    assign dv_c  = hz ? 32'd1 : cosc_reg[31:0];
    assign abs_u = nu3_reg[CW-1] ? CW'(-nu3_reg) : nu3_reg;
    assign abs_v = nv_reg[CW-1]  ? CW'(-nv_reg)  : nv_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            din_u_reg.r   <= 32'(abs_u[CW-1:8]);
            din_u_reg.nlo <= {abs_u[7:0], 24'b0};
            din_u_reg.q   <= '0;
            din_u_reg.c   <= dv_c;
            din_v_reg.r   <= 32'(abs_v[CW-1:8]);
            din_v_reg.nlo <= {abs_v[7:0], 24'b0};
            din_v_reg.q   <= '0;
            din_v_reg.c   <= dv_c;
            side_reg[0].neg_u <= nu3_reg[CW-1];
            side_reg[0].neg_v <= nv_reg[CW-1];
            side_reg[0].ovf_u <= 32'(abs_u[CW-1:8]) >= dv_c;
            side_reg[0].ovf_v <= 32'(abs_v[CW-1:8]) >= dv_c;
            side_reg[0].hz    <= hz;
            for (int s = 1; s <= DIV_STEPS; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign dw_u[0] = din_u_reg;
    assign dw_v[0] = din_v_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        gpc_div_cell u_du (.aclk(aclk), .en(adv), .d_in(dw_u[i]), .d_out(dw_u[i+1]));
        gpc_div_cell u_dv (.aclk(aclk), .en(adv), .d_in(dw_v[i]), .d_out(dw_v[i+1]));
    end

    function automatic logic [31:0] sat_q(input logic [31:0] q, input logic neg,
                                          input logic ovf);
        logic [31:0] r;
        if (!neg) begin
            r = (ovf || q[31]) ? 32'h7fff_ffff : q;
        end else begin
            r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
        end
        return r;
    endfunction

    side_t       sd;
    logic [31:0] u_out_reg, v_out_reg;
    logic        hz_out_reg;

    assign sd = side_reg[DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            hz_out_reg <= sd.hz;
            u_out_reg  <= sd.hz ? 32'd0 : sat_q(dw_u[DIV_STEPS].q, sd.neg_u, sd.ovf_u);
            v_out_reg  <= sd.hz ? 32'd0 : sat_q(dw_v[DIV_STEPS].q, sd.neg_v, sd.ovf_v);
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tlast  = lst_reg[NSTG-1];
    assign m_tuser  = hz_out_reg;
    assign m_tdata  = {v_out_reg, u_out_reg};

`ifndef SYNTHESIS
    a_hz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("horizon result with nonzero coordinates");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word not in first stage");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
